>>> rtl/ptst_pkg.sv
// Package for the periodic task tick scheduler.
// Holds field widths, command and result codes, parameter defaults and the
// control and status structs shared by the controller and the slot cells.
package ptst_pkg;

  localparam int TASKS_DEF       = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int FIELD_W = 16;
  localparam int KIND_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_CREATE  = 2'd1,
    CMD_SUSPEND = 2'd2,
    CMD_RESUME  = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS   = 2'd0,
    KIND_DISPATCH = 2'd1,
    KIND_DONE     = 2'd2
  } kind_e;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_TAKEN = 1'b1;

  // broadcast from the controller to every slot cell
  typedef struct packed {
    logic               step;
    logic               wr;
    cmd_e               cmd;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] first_delay;
  } cell_ctl_t;

  // gathered from the chain back to the controller
  typedef struct packed {
    logic fire;
    logic taken;
    logic last_tok;
  } chain_stat_t;

endpackage

>>> rtl/ptst_if.sv
// Valid/ready channel interfaces for the periodic task tick scheduler.
// Depends on ptst_pkg for field widths.
interface ptst_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptst_pkg::CMD_W-1:0]   cmd;
  logic [ptst_pkg::SLOT_W-1:0]  slot;
  logic [ptst_pkg::FIELD_W-1:0] period;
  logic [ptst_pkg::FIELD_W-1:0] first_delay;

  modport source (output valid, cmd, slot, period, first_delay, input ready);
  modport sink   (input valid, cmd, slot, period, first_delay, output ready);
endinterface

interface ptst_out_if;
  logic                        valid;
  logic                        ready;
  logic [ptst_pkg::KIND_W-1:0] kind;
  logic [ptst_pkg::SLOT_W-1:0] task_slot;
  logic                        status;
  logic                        last;

  modport source (output valid, kind, task_slot, status, last, input ready);
  modport sink   (input valid, kind, task_slot, status, last, output ready);
endinterface

>>> rtl/ptst_cell.sv
// One task slot of the scheduler chain: used and suspended bits, period and
// delay countdown, plus the walk token handed on to the next cell.
// Depends on ptst_pkg.
module ptst_cell #(
  parameter int INDEX       = 0,
  parameter int COUNT_WIDTH = ptst_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptst_pkg::cell_ctl_t ctl_i,
  input  logic                token_i,
  output logic                token_o,
  output logic                fire_o,
  output logic                taken_o
);

  logic                   used_q;
  logic                   susp_q;
  logic                   token_q;
  logic [COUNT_WIDTH-1:0] period_q;
  logic [COUNT_WIDTH-1:0] delay_q;
  logic                   match;
  logic                   zero;

  assign match   = (32'(ctl_i.slot) == INDEX);
  assign zero    = (delay_q == '0);
  assign fire_o  = token_q && used_q && !susp_q && zero;
  assign taken_o = match && used_q;
  assign token_o = token_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= 1'b0;
      susp_q   <= 1'b0;
      token_q  <= 1'b0;
      period_q <= '0;
      delay_q  <= '0;
    end else begin
      if (ctl_i.step) begin
        token_q <= token_i;
        if (token_q && !susp_q) begin
          if (zero) begin
            if (used_q) begin
              delay_q <= period_q - COUNT_WIDTH'(1);
            end
          end else begin
            delay_q <= delay_q - COUNT_WIDTH'(1);
          end
        end
      end
      if (ctl_i.wr && match) begin
        case (ctl_i.cmd)
          ptst_pkg::CMD_CREATE: begin
            if (!used_q) begin
              used_q   <= 1'b1;
              susp_q   <= 1'b0;
              period_q <= COUNT_WIDTH'(ctl_i.period);
              delay_q  <= COUNT_WIDTH'(ctl_i.first_delay);
            end
          end
          ptst_pkg::CMD_SUSPEND: susp_q <= 1'b1;
          ptst_pkg::CMD_RESUME:  susp_q <= 1'b0;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> rtl/ptst_ctrl.sv
// Sequencer of the scheduler: takes commands, walks the token through the
// slot chain on a tick and owns the result register.
// Depends on ptst_pkg and ptst_if.
module ptst_ctrl #(
  parameter int TASKS = ptst_pkg::TASKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ptst_in_if.sink               in_i,
  ptst_out_if.source            out_o,
  input  ptst_pkg::chain_stat_t stat_i,
  output ptst_pkg::cell_ctl_t   ctl_o
);

  localparam int PW = (TASKS > 1) ? $clog2(TASKS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  state_e                       state_q;
  logic [PW-1:0]                pos_q;
  logic                         out_valid_q;
  logic [ptst_pkg::KIND_W-1:0]  kind_q;
  logic [ptst_pkg::SLOT_W-1:0]  slot_q;
  logic                         status_q;
  logic                         last_q;

  logic   out_free;
  logic   accept;
  logic   is_tick;
  logic   slot_ok;
  ptst_pkg::cmd_e cmd;

  assign cmd      = ptst_pkg::cmd_e'(in_i.cmd);
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept   = in_i.valid && in_i.ready;
  assign is_tick  = (cmd == ptst_pkg::CMD_TICK);
  assign slot_ok  = (32'(in_i.slot) < TASKS);

  assign ctl_o.step        = (accept && is_tick) || ((state_q == S_WALK) && out_free);
  assign ctl_o.wr          = accept && !is_tick;
  assign ctl_o.cmd         = cmd;
  assign ctl_o.slot        = in_i.slot;
  assign ctl_o.period      = in_i.period;
  assign ctl_o.first_delay = in_i.first_delay;

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = kind_q;
  assign out_o.task_slot = slot_q;
  assign out_o.status    = status_q;
  assign out_o.last      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= ptst_pkg::KIND_STATUS;
      slot_q      <= '0;
      status_q    <= ptst_pkg::STATUS_OK;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (is_tick) begin
              state_q <= S_WALK;
              pos_q   <= '0;
            end else begin
              out_valid_q <= 1'b1;
              kind_q      <= ptst_pkg::KIND_STATUS;
              slot_q      <= in_i.slot;
              last_q      <= 1'b1;
              if ((cmd == ptst_pkg::CMD_CREATE) && (!slot_ok || stat_i.taken)) begin
                status_q <= ptst_pkg::STATUS_TAKEN;
              end else begin
                status_q <= ptst_pkg::STATUS_OK;
              end
            end
          end
        end
        S_WALK: begin
          if (out_free) begin
            pos_q <= pos_q + PW'(1);
            if (stat_i.fire) begin
              out_valid_q <= 1'b1;
              kind_q      <= ptst_pkg::KIND_DISPATCH;
              slot_q      <= ptst_pkg::SLOT_W'(pos_q);
              status_q    <= ptst_pkg::STATUS_OK;
              last_q      <= 1'b0;
            end
            if (stat_i.last_tok) begin
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= ptst_pkg::KIND_DONE;
            slot_q      <= '0;
            status_q    <= ptst_pkg::STATUS_OK;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler: a chain of TASKS slot cells with a sequencer.
// Depends on ptst_pkg, ptst_if, ptst_cell and ptst_ctrl.
//
// Usage:
//   in_i carries commands: tick, create task, suspend slot, resume slot.
//   out_o carries results: one status transaction per create/suspend/resume
//   (last set), or for a tick one dispatch transaction per task run in slot
//   order followed by a tick-done transaction with last set.
//   A command result appears in the cycle after its transaction is accepted.
//   A tick loads the token into the first cell, walks it along the chain one
//   cell at a time, and then issues the tick-done result.
//   One input transaction is in work at a time; in_i.ready is low during a
//   tick walk.
//   When the receiver stalls, the result register holds and the walk stops
//   until the register frees; no result is dropped.
//   Reset clears every slot to unused, resumed, period and delay zero.
module periodic_task_tick_scheduler #(
  parameter int TASKS       = ptst_pkg::TASKS_DEF,
  parameter int COUNT_WIDTH = ptst_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptst_in_if.sink    in_i,
  ptst_out_if.source out_o
);

  ptst_pkg::cell_ctl_t   ctl;
  ptst_pkg::chain_stat_t stat;
  logic [TASKS:0]        tok;
  logic [TASKS-1:0]      fire_vec;
  logic [TASKS-1:0]      taken_vec;

  assign tok[0] = ctl.step && !(|tok[TASKS:1]);

  for (genvar g = 0; g < TASKS; g++) begin : g_cell
    ptst_cell #(
      .INDEX      (g),
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .token_i(tok[g]),
      .token_o(tok[g+1]),
      .fire_o (fire_vec[g]),
      .taken_o(taken_vec[g])
    );
  end

  assign stat.fire     = |fire_vec;
  assign stat.taken    = |taken_vec;
  assign stat.last_tok = tok[TASKS];

  ptst_ctrl #(
    .TASKS(TASKS)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .out_o (out_o),
    .stat_i(stat),
    .ctl_o (ctl)
  );

endmodule

>>> rtl/ptst_checker.sv
// Port-level assertions for the periodic task tick scheduler.
// Depends on ptst_pkg; bound to periodic_task_tick_scheduler below.
module ptst_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [ptst_pkg::CMD_W-1:0]  in_cmd_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ptst_pkg::KIND_W-1:0] out_kind_i,
  input logic [ptst_pkg::SLOT_W-1:0] out_task_slot_i,
  input logic                        out_last_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
      && $stable(out_task_slot_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  a_cmd_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_cmd_i != ptst_pkg::CMD_TICK) |=> out_valid_i
      && (out_kind_i == ptst_pkg::KIND_STATUS) && out_last_i)
    else $error("command status missing");

  a_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_cmd_i == ptst_pkg::CMD_TICK) |=> !out_valid_i && !in_ready_i)
    else $error("tick start not clean");

  a_kind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_kind_i == ptst_pkg::KIND_DISPATCH && !out_last_i)
      || (out_kind_i == ptst_pkg::KIND_DONE && out_last_i && out_task_slot_i == '0)
      || (out_kind_i == ptst_pkg::KIND_STATUS && out_last_i))
    else $error("result kind and last disagree");

endmodule

bind periodic_task_tick_scheduler ptst_checker u_ptst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_cmd_i       (in_i.cmd),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_kind_i     (out_o.kind),
  .out_task_slot_i(out_o.task_slot),
  .out_last_i     (out_o.last)
);

>>> test/periodic_task_tick_scheduler_tb.sv
// Testbench for the periodic task tick scheduler: directed and random commands.
// Depends on ptst_pkg, ptst_if and the periodic_task_tick_scheduler RTL.
// Checks each result transaction against an in-bench model of the slot table.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_tb;

  localparam int TASKS       = ptst_pkg::TASKS_DEF;
  localparam int CMD_W       = ptst_pkg::CMD_W;
  localparam int SLOT_W      = ptst_pkg::SLOT_W;
  localparam int FIELD_W     = ptst_pkg::FIELD_W;
  localparam int STALL_LIMIT = 2000;
  localparam int CALM_FROM   = 2000;
  localparam int CALM_TO     = 3500;
  localparam int RAND_ITEMS  = 440;

  typedef struct {
    ptst_pkg::cmd_e     cmd;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] first_delay;
  } sched_cmd_t;

  typedef struct {
    ptst_pkg::kind_e   kind;
    logic [SLOT_W-1:0] task_slot;
    logic              status;
    logic              last;
  } sched_res_t;

  logic clk_i;
  logic rst_ni;

  ptst_in_if  in_if ();
  ptst_out_if out_if ();

  periodic_task_tick_scheduler u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  sched_cmd_t cmd_q[$];
  sched_res_t due_results_q[$];

  logic               slot_used_m [TASKS];
  logic               slot_susp_m [TASKS];
  logic [FIELD_W-1:0] slot_per_m  [TASKS];
  logic [FIELD_W-1:0] slot_dly_m  [TASKS];

  int unsigned cycle_cnt;
  int unsigned stall_cycles;
  int unsigned result_cnt;
  int unsigned mismatch_count;
  logic        in_fire;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic idle_roll();
    if (cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO) return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return FIELD_W'($urandom_range(6));
    if (r < 80) return '0;
    if (r < 85) return '1;
    return FIELD_W'($urandom);
  endfunction

  task automatic add_cmd(ptst_pkg::cmd_e c, int unsigned sl, int unsigned per,
                         int unsigned fd);
    sched_cmd_t it;
    it.cmd         = c;
    it.slot        = SLOT_W'(sl);
    it.period      = FIELD_W'(per);
    it.first_delay = FIELD_W'(fd);
    cmd_q.push_back(it);
  endtask

  task automatic push_result(ptst_pkg::kind_e k, logic [SLOT_W-1:0] sl, logic st,
                             logic lst);
    sched_res_t r;
    r.kind      = k;
    r.task_slot = sl;
    r.status    = st;
    r.last      = lst;
    due_results_q.push_back(r);
  endtask

  task automatic predict_schedule(sched_cmd_t c);
    logic st;
    st = ptst_pkg::STATUS_OK;
    if (c.cmd == ptst_pkg::CMD_TICK) begin
      for (int i = 0; i < TASKS; i++) begin
        if (!slot_susp_m[i]) begin
          if (slot_dly_m[i] == '0) begin
            if (slot_used_m[i]) begin
              push_result(ptst_pkg::KIND_DISPATCH, SLOT_W'(i), ptst_pkg::STATUS_OK, 1'b0);
              slot_dly_m[i] = slot_per_m[i] - 1'b1;
            end
          end else begin
            slot_dly_m[i] = slot_dly_m[i] - 1'b1;
          end
        end
      end
      push_result(ptst_pkg::KIND_DONE, '0, ptst_pkg::STATUS_OK, 1'b1);
    end else begin
      if (c.cmd == ptst_pkg::CMD_CREATE) begin
        if (!slot_used_m[c.slot]) begin
          slot_used_m[c.slot] = 1'b1;
          slot_per_m[c.slot]  = c.period;
          slot_dly_m[c.slot]  = c.first_delay;
          slot_susp_m[c.slot] = 1'b0;
        end else begin
          st = ptst_pkg::STATUS_TAKEN;
        end
      end else begin
        slot_susp_m[c.slot] = (c.cmd == ptst_pkg::CMD_SUSPEND);
      end
      push_result(ptst_pkg::KIND_STATUS, c.slot, st, 1'b1);
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR result %0d: %s", result_cnt, msg);
    mismatch_count++;
  endtask

  task automatic check_result();
    sched_res_t e;
    if (due_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction kind %0d slot %0d",
                                out_if.kind, out_if.task_slot));
    end else begin
      e = due_results_q.pop_front();
      if (out_if.kind !== e.kind)
        report_mismatch($sformatf("kind got %0d expected %0d", out_if.kind, e.kind));
      if (out_if.task_slot !== e.task_slot)
        report_mismatch($sformatf("task_slot got %0d expected %0d",
                                  out_if.task_slot, e.task_slot));
      if (out_if.status !== e.status)
        report_mismatch($sformatf("status got %0d expected %0d", out_if.status, e.status));
      if (out_if.last !== e.last)
        report_mismatch($sformatf("last got %0d expected %0d", out_if.last, e.last));
    end
    result_cnt++;
  endtask

  // driver: advance to the next transaction once the current one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !idle_roll();
      if (!in_if.valid || in_fire) begin
        if (cmd_q.size() > 0 && !idle_roll()) begin
          in_if.valid       <= 1'b1;
          in_if.cmd         <= cmd_q[0].cmd;
          in_if.slot        <= cmd_q[0].slot;
          in_if.period      <= cmd_q[0].period;
          in_if.first_delay <= cmd_q[0].first_delay;
          void'(cmd_q.pop_front());
        end else begin
          in_if.valid       <= 1'b0;
          in_if.cmd         <= CMD_W'($urandom);
          in_if.slot        <= SLOT_W'($urandom);
          in_if.period      <= FIELD_W'($urandom);
          in_if.first_delay <= FIELD_W'($urandom);
        end
      end
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    sched_cmd_t c;
    logic       out_fire;
    cycle_cnt++;
    in_fire  = rst_ni && in_if.valid && in_if.ready;
    out_fire = rst_ni && out_if.valid && out_if.ready;
    if (in_fire) begin
      c.cmd         = ptst_pkg::cmd_e'(in_if.cmd);
      c.slot        = in_if.slot;
      c.period      = in_if.period;
      c.first_delay = in_if.first_delay;
      predict_schedule(c);
    end
    if (out_fire) check_result();
    if (!rst_ni || in_fire || out_fire) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    in_fire           = 1'b0;
    cycle_cnt         = 0;
    stall_cycles      = 0;
    result_cnt        = 0;
    mismatch_count    = 0;
    in_if.valid       = 1'b0;
    in_if.cmd         = ptst_pkg::CMD_TICK;
    in_if.slot        = '0;
    in_if.period      = '0;
    in_if.first_delay = '0;
    out_if.ready      = 1'b0;
    for (int i = 0; i < TASKS; i++) begin
      slot_used_m[i] = 1'b0;
      slot_susp_m[i] = 1'b0;
      slot_per_m[i]  = '0;
      slot_dly_m[i]  = '0;
    end

    add_cmd(ptst_pkg::CMD_TICK, 0, 0, 0);
    add_cmd(ptst_pkg::CMD_SUSPEND, 3, 0, 0);
    add_cmd(ptst_pkg::CMD_RESUME, 3, 0, 0);
    add_cmd(ptst_pkg::CMD_CREATE, 0, 1, 0);
    add_cmd(ptst_pkg::CMD_CREATE, 15, 0, 0);
    add_cmd(ptst_pkg::CMD_CREATE, 0, 4, 4);
    add_cmd(ptst_pkg::CMD_CREATE, 5, 16'hffff, 16'hffff);
    add_cmd(ptst_pkg::CMD_TICK, 0, 0, 0);
    add_cmd(ptst_pkg::CMD_SUSPEND, 0, 0, 0);
    add_cmd(ptst_pkg::CMD_TICK, 0, 0, 0);
    add_cmd(ptst_pkg::CMD_RESUME, 0, 0, 0);
    add_cmd(ptst_pkg::CMD_CREATE, 7, 2, 1);
    add_cmd(ptst_pkg::CMD_TICK, 0, 0, 0);
    add_cmd(ptst_pkg::CMD_TICK, 0, 0, 0);
    add_cmd(ptst_pkg::CMD_TICK, 0, 0, 0);
    add_cmd(ptst_pkg::CMD_SUSPEND, 9, 0, 0);
    add_cmd(ptst_pkg::CMD_CREATE, 9, 3, 0);
    add_cmd(ptst_pkg::CMD_TICK, 0, 0, 0);
    add_cmd(ptst_pkg::CMD_SUSPEND, 15, 0, 0);
    add_cmd(ptst_pkg::CMD_TICK, 0, 0, 0);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(99);
      if (r < 50)
        add_cmd(ptst_pkg::CMD_TICK, $urandom, $urandom, $urandom);
      else if (r < 70)
        add_cmd(ptst_pkg::CMD_CREATE, $urandom_range(15), pick_count(), pick_count());
      else if (r < 82)
        add_cmd(ptst_pkg::CMD_SUSPEND, $urandom_range(15), $urandom, $urandom);
      else
        add_cmd(ptst_pkg::CMD_RESUME, $urandom_range(15), $urandom, $urandom);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (cmd_q.size() == 0 && !in_if.valid);
    wait (due_results_q.size() == 0);
    repeat (TASKS + 10) @(posedge clk_i);
    if (mismatch_count == 0 && due_results_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> periodic_task_tick_scheduler.f
rtl/ptst_pkg.sv
rtl/ptst_if.sv
rtl/ptst_cell.sv
rtl/ptst_ctrl.sv
rtl/periodic_task_tick_scheduler.sv
rtl/ptst_checker.sv
test/periodic_task_tick_scheduler_tb.sv
